// ===== rtl/cuvd_pkg.sv =====
// Shared types and constants for the cell undervoltage debounce block.
// No dependencies; cuvd_eval.sv and the top level refer to it by scoped names.
package cuvd_pkg;

  // Per-entry debounce flag.
  typedef enum logic [1:0] {
    FLAG_IDLE      = 2'd0,
    FLAG_SETTING   = 2'd1,
    FLAG_SET       = 2'd2,
    FLAG_RELEASING = 2'd3
  } flag_e;

  // Event code carried in the result word.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SET     = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CELL_COUNT = 2'd0;
  localparam logic [1:0] CFG_LEVEL0     = 2'd1;
  localparam logic [1:0] CFG_LEVEL1     = 2'd2;
  localparam logic [1:0] CFG_LEVEL2     = 2'd3;

  localparam int unsigned CfgDataW     = 48;
  localparam int unsigned CellCountW   = 5;
  localparam int unsigned CellCountRst = 16;
  localparam int unsigned NumLevelRegs = 3;

  // Thresholds and debounce times of one protection level.
  typedef struct packed {
    logic [7:0]  rel_time;
    logic [15:0] rel_mv;
    logic [7:0]  set_time;
    logic [15:0] set_mv;
  } level_params_t;

  // State kept for one (level, cell) pair.
  typedef struct packed {
    flag_e      flag;
    logic [7:0] set_cnt;
    logic [7:0] rel_cnt;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== rtl/cuvd_if.sv =====
// Valid/ready channel interfaces for sample words and result words.
// Depends on nothing but the port widths of the block.
interface cuvd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  prot_level;
  logic [15:0] cell_voltage;

  modport source (output valid, output prot_level, output cell_voltage, input ready);
  modport sink   (input valid, input prot_level, input cell_voltage, output ready);
endinterface

interface cuvd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [1:0] event_level;
  logic [3:0] event_cell;
  logic       sweep_done;

  modport source (output valid, output event_kind, output event_level,
                  output event_cell, output sweep_done, input ready);
  modport sink   (input valid, input event_kind, input event_level,
                  input event_cell, input sweep_done, output ready);
endinterface

// ===== rtl/cuvd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cuvd_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 48
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cuvd_eval.sv =====
// Debounce update for one (level, cell) entry: set and release checks.
// Depends on cuvd_pkg for the entry, parameter and event types.
module cuvd_eval (
  input  cuvd_pkg::entry_t        cur_i,
  input  cuvd_pkg::level_params_t params_i,
  input  logic [15:0]             voltage_i,
  output cuvd_pkg::entry_t        next_o,
  output cuvd_pkg::event_kind_e   kind_o
);

  cuvd_pkg::flag_e       flag;
  logic [7:0]            set_cnt;
  logic [7:0]            rel_cnt;
  cuvd_pkg::event_kind_e kind;

  // The set check runs first; its result feeds the release check of the same word.
  always_comb begin
    flag    = cur_i.flag;
    set_cnt = cur_i.set_cnt;
    rel_cnt = cur_i.rel_cnt;
    kind    = cuvd_pkg::EV_NONE;

    if ((voltage_i < params_i.set_mv) && (params_i.set_time != 8'd0)) begin
      if (flag == cuvd_pkg::FLAG_IDLE) begin
        flag    = cuvd_pkg::FLAG_SETTING;
        set_cnt = 8'd1;
      end else if (flag == cuvd_pkg::FLAG_SETTING) begin
        set_cnt = set_cnt + 8'd1;
        if (set_cnt >= params_i.set_time) begin
          kind    = cuvd_pkg::EV_SET;
          flag    = cuvd_pkg::FLAG_SET;
          set_cnt = 8'd0;
        end
      end
    end else if (flag == cuvd_pkg::FLAG_SETTING) begin
      flag = cuvd_pkg::FLAG_IDLE;
    end

    if ((voltage_i > params_i.rel_mv) && (params_i.rel_time != 8'd0)) begin
      if (flag == cuvd_pkg::FLAG_SET) begin
        flag    = cuvd_pkg::FLAG_RELEASING;
        rel_cnt = 8'd1;
      end else if (flag == cuvd_pkg::FLAG_RELEASING) begin
        rel_cnt = rel_cnt + 8'd1;
        if (rel_cnt >= params_i.rel_time) begin
          flag    = cuvd_pkg::FLAG_IDLE;
          rel_cnt = 8'd0;
          kind    = cuvd_pkg::EV_RELEASE;
        end
      end
    end else if (flag == cuvd_pkg::FLAG_RELEASING) begin
      flag = cuvd_pkg::FLAG_SET;
    end
  end

  assign next_o.flag    = flag;
  assign next_o.set_cnt = set_cnt;
  assign next_o.rel_cnt = rel_cnt;
  assign kind_o         = kind;

endmodule

// ===== rtl/cell_undervoltage_debounce.sv =====
// Cell undervoltage debounce: top level with cursor, config, state RAM and output register.
// A word accepted passes through the stage 1 registers and then the output register.
// Throughput: one word per cycle unless the output stalls; the state RAM is read at accept
// and written as the word leaves stage 1; a one-entry forward covers back-to-back hits.
// Reset: all flags idle and counters zero through per-entry valid bits,
// cursor 0, cell count 16, level parameters 0; no clearing pass.
module cell_undervoltage_debounce #(
  parameter int unsigned MAX_CELLS  = 16,
  parameter int unsigned NUM_LEVELS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cuvd_in_if.sink                           in_ch,
  cuvd_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [cuvd_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned Depth = MAX_CELLS * NUM_LEVELS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CurW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned CntW  = ($clog2(MAX_CELLS + 1) > cuvd_pkg::CellCountW) ?
                                  $clog2(MAX_CELLS + 1) : cuvd_pkg::CellCountW;

  // Configuration registers.
  logic [cuvd_pkg::CellCountW-1:0] cell_count_q;
  cuvd_pkg::level_params_t         lvl_params_q [cuvd_pkg::NumLevelRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= cuvd_pkg::CellCountW'(cuvd_pkg::CellCountRst);
      for (int i = 0; i < int'(cuvd_pkg::NumLevelRegs); i++) begin
        lvl_params_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cuvd_pkg::CFG_CELL_COUNT: cell_count_q <= cfg_data_i[cuvd_pkg::CellCountW-1:0];
        cuvd_pkg::CFG_LEVEL0:     lvl_params_q[0] <= cfg_data_i;
        cuvd_pkg::CFG_LEVEL1:     lvl_params_q[1] <= cfg_data_i;
        cuvd_pkg::CFG_LEVEL2:     lvl_params_q[2] <= cfg_data_i;
        default:                  cell_count_q <= cell_count_q;
      endcase
    end
  end

  // Handshake and stage control.
  logic in_acc;
  logic s1_valid_q;
  logic s1_adv;
  logic out_valid_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Cell cursor: the effective count is clamped to 1..MAX_CELLS.
  logic [CurW-1:0] cursor_q;
  logic [CurW-1:0] cursor_d;
  logic [CntW-1:0] cnt_raw;
  logic [CntW-1:0] cnt_eff;
  logic [CntW-1:0] cursor_inc;
  logic            wrap;

  assign cnt_raw    = CntW'(cell_count_q);
  assign cnt_eff    = (cnt_raw == '0) ? CntW'(1) :
                      ((cnt_raw > CntW'(MAX_CELLS)) ? CntW'(MAX_CELLS) : cnt_raw);
  assign cursor_inc = CntW'(cursor_q) + CntW'(1);
  assign wrap       = (cursor_inc >= cnt_eff);
  assign cursor_d   = wrap ? '0 : CurW'(cursor_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (in_acc) begin
      cursor_q <= cursor_d;
    end
  end

  // Entry address of the incoming word.
  logic             in_lvl_ok;
  logic [AddrW-1:0] in_addr;

  assign in_lvl_ok = (int'(in_ch.prot_level) < int'(NUM_LEVELS));
  assign in_addr   = AddrW'(int'(in_ch.prot_level) * int'(MAX_CELLS) + int'(cursor_q));

  // Stage 1 registers: the word under evaluation.
  logic             s1_lvl_ok_q;
  logic [1:0]       s1_level_q;
  logic [15:0]      s1_voltage_q;
  logic [CurW-1:0]  s1_cell_q;
  logic             s1_done_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             byp_q;
  logic             byp_d;
  cuvd_pkg::entry_t fwd_q;

  logic             s1_we;
  cuvd_pkg::entry_t s1_next;

  assign s1_we = s1_adv && s1_lvl_ok_q;
  assign byp_d = s1_we && (s1_addr_q == in_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      byp_q      <= byp_d;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_lvl_ok_q  <= in_lvl_ok;
      s1_level_q   <= in_ch.prot_level;
      s1_voltage_q <= in_ch.cell_voltage;
      s1_cell_q    <= cursor_q;
      s1_done_q    <= wrap;
      s1_addr_q    <= in_addr;
      fwd_q        <= s1_next;
    end
  end

  // State RAM and per-entry valid bits standing in for the reset value.
  logic [Depth-1:0]           valid_q;
  logic [cuvd_pkg::EntryW-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (s1_we) begin
      valid_q[s1_addr_q] <= 1'b1;
    end
  end

  cuvd_ram #(
    .WIDTH (cuvd_pkg::EntryW),
    .DEPTH (Depth)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_next),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Current entry: forwarded word, stored word, or the reset value.
  cuvd_pkg::entry_t        s1_cur;
  cuvd_pkg::level_params_t s1_params;
  cuvd_pkg::event_kind_e   s1_kind;

  always_comb begin
    if (byp_q) begin
      s1_cur = fwd_q;
    end else if (valid_q[s1_addr_q]) begin
      s1_cur = cuvd_pkg::entry_t'(ram_rdata);
    end else begin
      s1_cur = '0;
    end
  end

  assign s1_params = lvl_params_q[s1_lvl_ok_q ? s1_level_q : 2'd0];

  cuvd_eval u_eval (
    .cur_i     (s1_cur),
    .params_i  (s1_params),
    .voltage_i (s1_voltage_q),
    .next_o    (s1_next),
    .kind_o    (s1_kind)
  );

  // Output register.
  logic [1:0] out_kind_q;
  logic [1:0] out_level_q;
  logic [3:0] out_cell_q;
  logic       out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_kind_q  <= s1_lvl_ok_q ? s1_kind : cuvd_pkg::EV_NONE;
      out_level_q <= s1_level_q;
      out_cell_q  <= 4'(s1_cell_q);
      out_done_q  <= s1_done_q;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.event_kind  = out_kind_q;
  assign out_ch.event_level = out_level_q;
  assign out_ch.event_cell  = out_cell_q;
  assign out_ch.sweep_done  = out_done_q;

  // The cursor never leaves the range 0..MAX_CELLS-1.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cursor_q) < int'(MAX_CELLS))
    else $error("cell cursor out of range");

  // An event is only reported for a protection level that exists.
  a_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q != cuvd_pkg::EV_NONE)) |->
      (int'(out_level_q) < int'(NUM_LEVELS)))
    else $error("event on an unused protection level");

  // Forwarding is armed only by a state write at the accept edge.
  a_bypass_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_acc) && byp_q |-> $past(s1_we))
    else $error("forward path armed without a state write");

endmodule
